/* hw/rtl/mjs_pkg.sv */
// Shared types, codes and the job ordering function for the multicore job scheduler.
// No dependencies; used by mjs_ctrl, mjs_datapath and multicore_job_scheduler_core.
package mjs_pkg;

  localparam int MAX_CORES_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam logic [24:0] NO_START = 25'h1000000;
  localparam logic [39:0] MAX40    = 40'hFF_FFFF_FFFF;

  localparam logic [2:0] SCH_FCFS = 3'd0;
  localparam logic [2:0] SCH_SJF  = 3'd1;
  localparam logic [2:0] SCH_PSJF = 3'd2;
  localparam logic [2:0] SCH_PRI  = 3'd3;
  localparam logic [2:0] SCH_PPRI = 3'd4;
  localparam logic [2:0] SCH_RR   = 3'd5;

  localparam logic [1:0] ACT_ARRIVE = 2'd0;
  localparam logic [1:0] ACT_FINISH = 2'd1;
  localparam logic [1:0] ACT_EXPIRE = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_CORE = 2'd1;
  localparam logic [1:0] KIND_JOB  = 2'd2;

  localparam logic CFG_SCHEME = 1'b0;
  localparam logic CFG_CORES  = 1'b1;

  typedef struct packed {
    logic [15:0] num;
    logic [23:0] arr;
    logic [24:0] start;
    logic [23:0] len;
    logic [24:0] rem;
    logic [15:0] pri;
  } slot_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_ADV, OP_PLACE_IDLE, OP_PREEMPT, OP_SET_INS_NEW,
    OP_FINISH, OP_HEAD_RD, OP_DISPATCH, OP_REPLY_CUR, OP_EXP_SWAP,
    OP_SCAN_INIT, OP_SCAN_RD, OP_SCAN_NEXT, OP_SHIFT_INIT, OP_SHIFT_RD,
    OP_SHIFT_WR, OP_INS_WR, OP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADV, ST_DECIDE, ST_HEAD_RD, ST_HEAD_USE, ST_SCAN_INIT,
    ST_SCAN_RD, ST_SCAN_CMP, ST_SHIFT_INIT, ST_SHIFT_RD, ST_SHIFT_WR, ST_FIN
  } state_t;

  typedef struct packed {
    logic [1:0] act;
    logic       ci_ok;
    logic       busy_ci;
    logic       idle_found;
    logic       victim_found;
    logic       preemptive;
    logic       q_nonzero;
    logic       q_full;
    logic       adv_last;
    logic       scan_done;
    logic       scan_hit;
    logic       shift_done;
    logic       exp_keep;
  } dp_status_t;

  // true when a strictly precedes b
  function automatic logic before_f(logic [2:0] sch, slot_t a, slot_t b);
    logic lt;
    logic gt;
    lt = 1'b0;
    gt = 1'b0;
    if (sch == SCH_RR || a.num == b.num) return 1'b0;
    if (sch == SCH_SJF || sch == SCH_PSJF) begin
      lt = a.rem < b.rem;
      gt = a.rem > b.rem;
    end else if (sch == SCH_PRI || sch == SCH_PPRI) begin
      lt = a.pri < b.pri;
      gt = a.pri > b.pri;
    end
    if (lt) return 1'b1;
    if (gt) return 1'b0;
    return a.arr < b.arr;
  endfunction

endpackage

/* hw/rtl/mjs_ctrl.sv */
// Controller state machine of the multicore job scheduler.
// Depends on mjs_pkg; drives mjs_datapath through dp_op_t commands.
module mjs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  mjs_pkg::dp_status_t st,
  output mjs_pkg::dp_op_t     op
);
  import mjs_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FIN && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (s_tvalid) state_next = ST_ADV;
      ST_ADV:        if (st.adv_last) state_next = ST_DECIDE;
      ST_DECIDE: begin
        state_next = ST_FIN;
        if (st.act == ACT_ARRIVE) begin
          if (!st.idle_found && !st.q_full) state_next = ST_SCAN_INIT;
        end else if ((st.act == ACT_FINISH || st.act == ACT_EXPIRE) && st.ci_ok) begin
          if (st.q_nonzero) state_next = ST_HEAD_RD;
        end
      end
      ST_HEAD_RD:    state_next = ST_HEAD_USE;
      ST_HEAD_USE:   state_next = (st.busy_ci && !st.exp_keep) ? ST_SCAN_INIT : ST_FIN;
      ST_SCAN_INIT:  state_next = ST_SCAN_RD;
      ST_SCAN_RD:    state_next = st.scan_done ? ST_SHIFT_INIT : ST_SCAN_CMP;
      ST_SCAN_CMP:   state_next = st.scan_hit ? ST_SHIFT_INIT : ST_SCAN_RD;
      ST_SHIFT_INIT: state_next = ST_SHIFT_RD;
      ST_SHIFT_RD:   state_next = st.shift_done ? ST_FIN : ST_SHIFT_WR;
      ST_SHIFT_WR:   state_next = ST_SHIFT_RD;
      ST_FIN:        if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    op = OP_NONE;
    unique case (state)
      ST_IDLE: if (s_tvalid) op = OP_LATCH;
      ST_ADV:  op = OP_ADV;
      ST_DECIDE: begin
        if (st.act == ACT_ARRIVE) begin
          if (st.idle_found) op = OP_PLACE_IDLE;
          else if (!st.q_full && st.preemptive && st.victim_found) op = OP_PREEMPT;
          else if (!st.q_full) op = OP_SET_INS_NEW;
        end else if (st.act == ACT_FINISH && st.ci_ok) begin
          op = OP_FINISH;
        end else if (st.act == ACT_EXPIRE && st.ci_ok) begin
          if (st.busy_ci && !st.q_nonzero) op = OP_REPLY_CUR;
        end
      end
      ST_HEAD_RD: op = OP_HEAD_RD;
      ST_HEAD_USE: begin
        if (!st.busy_ci) op = OP_DISPATCH;
        else if (st.exp_keep) op = OP_REPLY_CUR;
        else op = OP_EXP_SWAP;
      end
      ST_SCAN_INIT:  op = OP_SCAN_INIT;
      ST_SCAN_RD:    if (!st.scan_done) op = OP_SCAN_RD;
      ST_SCAN_CMP:   if (!st.scan_hit) op = OP_SCAN_NEXT;
      ST_SHIFT_INIT: op = OP_SHIFT_INIT;
      ST_SHIFT_RD:   op = st.shift_done ? OP_INS_WR : OP_SHIFT_RD;
      ST_SHIFT_WR:   op = OP_SHIFT_WR;
      ST_FIN:        if (out_free) op = OP_OUT;
      default:       op = OP_NONE;
    endcase
  end

endmodule

/* hw/rtl/mjs_datapath.sv */
// Datapath of the multicore job scheduler: core slots, ordered wait queue memory,
// totals and result registers. Depends on mjs_pkg; commanded by mjs_ctrl.
module mjs_datapath #(
  parameter int MAX_CORES   = mjs_pkg::MAX_CORES_DEF,
  parameter int QUEUE_DEPTH = mjs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  mjs_pkg::dp_op_t     op,
  output mjs_pkg::dp_status_t st,
  input  logic [1:0]          in_action,
  input  logic [15:0]         in_job_id,
  input  logic [23:0]         in_now,
  input  logic [23:0]         in_run_length,
  input  logic [15:0]         in_job_priority,
  input  logic [2:0]          in_core_index,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [3:0]          cfg_data,
  output logic [1:0]          reply_kind,
  output logic [15:0]         reply_value,
  output logic [31:0]         jobs_finished,
  output logic [39:0]         waiting_sum,
  output logic [39:0]         turnaround_sum,
  output logic [39:0]         response_sum
);
  import mjs_pkg::*;

  localparam int CW  = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int NW  = $clog2(MAX_CORES + 1);
  localparam int CIW = (CW > 3) ? CW : 3;
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int KW  = $clog2(QUEUE_DEPTH + 1);

  logic [2:0]  scheme;
  logic [3:0]  active_cores;
  logic [2:0]  sch_q;
  logic [NW-1:0] n_q;
  logic [1:0]  act_q;
  logic [2:0]  ci_q;
  logic [23:0] now_q;
  logic [23:0] dt_q;
  logic [23:0] last_time;
  slot_t       job_q;

  logic [MAX_CORES-1:0] core_busy;
  slot_t       core_slot [MAX_CORES];
  logic [CW-1:0] idx;
  logic        idle_found;
  logic [CW-1:0] idle_idx;
  logic        victim_found;
  logic [CW-1:0] victim;
  slot_t       cand;
  slot_t       ins;

  slot_t       qmem [QUEUE_DEPTH];
  slot_t       rd_data;
  logic        mem_re;
  logic [QW-1:0] mem_ra;
  logic        mem_we;
  logic [QW-1:0] mem_wa;
  slot_t       mem_wd;
  logic [QW-1:0] head;
  logic [KW-1:0] count;
  logic [KW-1:0] k;
  logic [QW-1:0] ptr;
  logic [QW-1:0] dst;
  logic [KW-1:0] dk;

  logic [1:0]  kind_r;
  logic [15:0] val_r;
  logic [31:0] finished_count;
  logic [39:0] waiting_total;
  logic [39:0] turnaround_total;
  logic [39:0] response_total;

  logic [CIW-1:0] ci_wide;
  logic [CW-1:0]  ci_idx;
  logic [CW-1:0]  core_addr;
  slot_t          cur;
  logic           cur_busy;
  logic [24:0]    rem_new;
  slot_t          c_upd;
  slot_t          head_fix;
  slot_t          vict_fix;
  slot_t          job_run;
  logic [QW-1:0]  src;
  logic [QW:0]    tail_sum;
  logic [QW-1:0]  tail;
  int unsigned    ac_w;
  int unsigned    n_eff;
  logic [24:0]    arr_len;
  logic [23:0]    wait_term;
  logic [23:0]    turn_term;
  logic [24:0]    resp_term;
  logic [40:0]    wait_add;
  logic [40:0]    turn_add;
  logic [40:0]    resp_add;

  function automatic logic [QW-1:0] inc_p(logic [QW-1:0] p);
    return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + QW'(1);
  endfunction

  function automatic logic [QW-1:0] dec_p(logic [QW-1:0] p);
    return (p == '0) ? QW'(QUEUE_DEPTH - 1) : p - QW'(1);
  endfunction

  assign ci_wide = CIW'(ci_q);
  assign ci_idx  = ci_wide[CW-1:0];

  always_comb begin
    unique case (op)
      OP_ADV:        core_addr = idx;
      OP_PLACE_IDLE: core_addr = idle_idx;
      OP_PREEMPT:    core_addr = victim;
      default:       core_addr = ci_idx;
    endcase
  end

  assign cur      = core_slot[core_addr];
  assign cur_busy = core_busy[core_addr];
  assign rem_new  = (cur.rem > {1'b0, dt_q}) ? cur.rem - {1'b0, dt_q} : '0;

  always_comb begin
    c_upd     = cur;
    c_upd.rem = rem_new;
    head_fix  = rd_data;
    if (rd_data.start[24]) head_fix.start = {1'b0, now_q};
    vict_fix  = cur;
    if (cur.start == {1'b0, now_q}) vict_fix.start = NO_START;
    job_run       = job_q;
    job_run.start = {1'b0, now_q};
  end

  assign tail_sum = (QW+1)'(head) + (QW+1)'(count);
  assign tail     = (32'(tail_sum) >= QUEUE_DEPTH) ? QW'(32'(tail_sum) - QUEUE_DEPTH)
                                                   : tail_sum[QW-1:0];
  assign src      = dec_p(dst);

  always_comb begin
    ac_w  = 32'(active_cores);
    n_eff = (ac_w == 0) ? 1 : ((ac_w > MAX_CORES) ? MAX_CORES : ac_w);
  end

  always_comb begin
    arr_len   = {1'b0, cur.arr} + {1'b0, cur.len};
    wait_term = now_q - cur.arr - cur.len;
    turn_term = now_q - cur.arr;
    resp_term = cur.start - {1'b0, cur.arr};
    wait_add  = {1'b0, waiting_total} +
                (({1'b0, now_q} >= arr_len) ? 41'(wait_term) : 41'd0);
    turn_add  = {1'b0, turnaround_total} + ((now_q >= cur.arr) ? 41'(turn_term) : 41'd0);
    resp_add  = {1'b0, response_total} +
                ((!cur.start[24] && cur.start >= {1'b0, cur.arr}) ? 41'(resp_term) : 41'd0);
  end

  always_comb begin
    st.act          = act_q;
    st.ci_ok        = 32'(ci_q) < 32'(n_q);
    st.busy_ci      = core_busy[ci_idx];
    st.idle_found   = idle_found;
    st.victim_found = victim_found;
    st.preemptive   = (sch_q == SCH_PSJF) || (sch_q == SCH_PPRI);
    st.q_nonzero    = count != '0;
    st.q_full       = 32'(count) >= QUEUE_DEPTH;
    st.adv_last     = NW'(idx) == n_q - NW'(1);
    st.scan_done    = k == count;
    st.scan_hit     = before_f(sch_q, ins, rd_data);
    st.shift_done   = dk == k;
    st.exp_keep     = before_f(sch_q, core_slot[ci_idx], rd_data);
  end

  always_comb begin
    mem_re = 1'b0;
    mem_ra = head;
    mem_we = 1'b0;
    mem_wa = dst;
    mem_wd = ins;
    case (op)
      OP_HEAD_RD:  mem_re = 1'b1;
      OP_SCAN_RD: begin
        mem_re = 1'b1;
        mem_ra = ptr;
      end
      OP_SHIFT_RD: begin
        mem_re = 1'b1;
        mem_ra = src;
      end
      OP_SHIFT_WR: begin
        mem_we = 1'b1;
        mem_wd = rd_data;
      end
      OP_INS_WR:   mem_we = 1'b1;
      default:     mem_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) qmem[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= qmem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scheme           <= SCH_FCFS;
      active_cores     <= 4'd8;
      core_busy        <= '0;
      head             <= '0;
      count            <= '0;
      last_time        <= '0;
      finished_count   <= '0;
      waiting_total    <= '0;
      turnaround_total <= '0;
      response_total   <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SCHEME) scheme <= cfg_data[2:0];
        else active_cores <= cfg_data;
      end
      unique case (op)
        OP_LATCH: begin
          act_q        <= in_action;
          ci_q         <= in_core_index;
          now_q        <= in_now;
          dt_q         <= (in_now >= last_time) ? in_now - last_time : '0;
          last_time    <= in_now;
          sch_q        <= (scheme > SCH_RR) ? SCH_FCFS : scheme;
          n_q          <= NW'(n_eff);
          job_q.num    <= in_job_id;
          job_q.arr    <= in_now;
          job_q.start  <= NO_START;
          job_q.len    <= in_run_length;
          job_q.rem    <= {1'b0, in_run_length};
          job_q.pri    <= in_job_priority;
          cand.num     <= in_job_id;
          cand.arr     <= in_now;
          cand.start   <= NO_START;
          cand.len     <= in_run_length;
          cand.rem     <= {1'b0, in_run_length};
          cand.pri     <= in_job_priority;
          idx          <= '0;
          idle_found   <= 1'b0;
          victim_found <= 1'b0;
          kind_r       <= KIND_NONE;
          val_r        <= '0;
        end
        OP_ADV: begin
          if (cur_busy) core_slot[idx].rem <= rem_new;
          if (!cur_busy && !idle_found) begin
            idle_found <= 1'b1;
            idle_idx   <= idx;
          end
          if (before_f(sch_q, cand, c_upd)) begin
            victim_found <= 1'b1;
            victim       <= idx;
            cand         <= c_upd;
          end
          idx <= idx + CW'(1);
        end
        OP_PLACE_IDLE: begin
          core_busy[idle_idx] <= 1'b1;
          core_slot[idle_idx] <= job_run;
          kind_r              <= KIND_CORE;
          val_r               <= 16'(idle_idx);
        end
        OP_PREEMPT: begin
          ins               <= vict_fix;
          core_slot[victim] <= job_run;
          kind_r            <= KIND_CORE;
          val_r             <= 16'(victim);
        end
        OP_SET_INS_NEW: ins <= job_q;
        OP_FINISH: begin
          if (cur_busy) begin
            if (finished_count != 32'hFFFF_FFFF) finished_count <= finished_count + 32'd1;
            waiting_total    <= (wait_add > 41'(MAX40)) ? MAX40 : wait_add[39:0];
            turnaround_total <= (turn_add > 41'(MAX40)) ? MAX40 : turn_add[39:0];
            response_total   <= (resp_add > 41'(MAX40)) ? MAX40 : resp_add[39:0];
            core_busy[ci_idx] <= 1'b0;
          end
        end
        OP_DISPATCH: begin
          core_busy[ci_idx] <= 1'b1;
          core_slot[ci_idx] <= head_fix;
          head              <= inc_p(head);
          count             <= count - KW'(1);
          kind_r            <= KIND_JOB;
          val_r             <= rd_data.num;
        end
        OP_REPLY_CUR: begin
          kind_r <= KIND_JOB;
          val_r  <= cur.num;
        end
        OP_EXP_SWAP: begin
          ins               <= cur;
          core_slot[ci_idx] <= head_fix;
          head              <= inc_p(head);
          count             <= count - KW'(1);
          kind_r            <= KIND_JOB;
          val_r             <= rd_data.num;
        end
        OP_SCAN_INIT: begin
          k   <= '0;
          ptr <= head;
        end
        OP_SCAN_NEXT: begin
          k   <= k + KW'(1);
          ptr <= inc_p(ptr);
        end
        OP_SHIFT_INIT: begin
          dst <= tail;
          dk  <= count;
        end
        OP_SHIFT_WR: begin
          dst <= src;
          dk  <= dk - KW'(1);
        end
        OP_INS_WR: count <= count + KW'(1);
        OP_OUT: begin
          reply_kind     <= kind_r;
          reply_value    <= val_r;
          jobs_finished  <= finished_count;
          waiting_sum    <= waiting_total;
          turnaround_sum <= turnaround_total;
          response_sum   <= response_total;
        end
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/multicore_job_scheduler_core.sv */
// Top level of the multicore job scheduler: stream ports, config port, ctrl and datapath.
// Depends on mjs_pkg, mjs_ctrl and mjs_datapath.
//
//   channel  | direction | beat contents
//   s_*      | in        | one event: action, job, time, length, priority, core
//   m_*      | out       | one reply with running totals per event
//   cfg_*    | in        | register write: 0 scheme, 1 active_cores
//
// One event steps through accept, an advance step for each active core, decide and reply,
// plus a read of the queue head, and when a job joins the queue a read per entry scanned or
// moved; the wait queue memory with its single read port sets the pace.
// Reset is synchronous; no clearing pass is needed.
// A finished reply waits in the output register while the next event is taken.
module multicore_job_scheduler_core #(
  parameter int MAX_CORES   = mjs_pkg::MAX_CORES_DEF,
  parameter int QUEUE_DEPTH = mjs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [87:0]  s_tdata,   // job_id, now, run_length, job_priority, core_index, pad
  input  logic [1:0]   s_tuser,   // action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [167:0] m_tdata,   // reply_value, jobs_finished, waiting_sum,
                                  // turnaround_sum, response_sum
  output logic [1:0]   m_tuser,   // reply_kind
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [3:0]   cfg_data
);
  import mjs_pkg::*;

  dp_op_t     op;
  dp_status_t st;

  mjs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .op       (op)
  );

  mjs_datapath #(
    .MAX_CORES   (MAX_CORES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .st              (st),
    .in_action       (s_tuser),
    .in_job_id       (s_tdata[15:0]),
    .in_now          (s_tdata[39:16]),
    .in_run_length   (s_tdata[63:40]),
    .in_job_priority (s_tdata[79:64]),
    .in_core_index   (s_tdata[82:80]),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .reply_kind      (m_tuser),
    .reply_value     (m_tdata[15:0]),
    .jobs_finished   (m_tdata[47:16]),
    .waiting_sum     (m_tdata[87:48]),
    .turnaround_sum  (m_tdata[127:88]),
    .response_sum    (m_tdata[167:128])
  );

endmodule

/* dv/multicore_job_scheduler_core_tb.sv */
// Self-checking testbench for multicore_job_scheduler_core: drives scheduling events on the
// input stream, predicts each reply and the running totals, and compares every result beat.
// Depends on mjs_pkg and the scheduler RTL.
module multicore_job_scheduler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mjs_pkg::*;

  localparam int NCORES = 8;
  localparam int QDEPTH = 64;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [1:0] ACT_BAD = 2'd3;

  typedef struct {
    logic [15:0] num;
    logic [23:0] arr;
    logic [24:0] start;
    logic [23:0] len;
    logic [24:0] rem;
    logic [15:0] pri;
  } job_t;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] value;
    logic [31:0] finished;
    logic [39:0] waiting;
    logic [39:0] turnaround;
    logic [39:0] response;
  } reply_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [87:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [167:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [3:0] cfg_data = '0;

  multicore_job_scheduler_core u_top (.*);

  initial forever #5 clk = ~clk;

  // predictor state
  logic [2:0] sched_mode;
  logic [3:0] core_limit;
  logic core_on [NCORES];
  job_t core_slot [NCORES];
  job_t wait_q [$];
  logic [23:0] prev_now;
  logic [31:0] fin_cnt;
  logic [39:0] wait_tot, turn_tot, resp_tot;

  reply_t expected_replies [$];
  int errors = 0;
  longint cycles = 0;
  logic [23:0] clock_now = 0;

  function automatic logic [2:0] mode_eff();
    return sched_mode > SCH_RR ? SCH_FCFS : sched_mode;
  endfunction

  function automatic int cores_eff();
    if (core_limit < 4'd1) return 1;
    if (int'(core_limit) > NCORES) return NCORES;
    return int'(core_limit);
  endfunction

  function automatic bit precedes(job_t a, job_t b);
    logic [2:0] m;
    m = mode_eff();
    if (m == SCH_RR || a.num == b.num) return 0;
    if (m == SCH_SJF || m == SCH_PSJF) begin
      if (a.rem != b.rem) return a.rem < b.rem;
    end else if (m == SCH_PRI || m == SCH_PPRI) begin
      if (a.pri != b.pri) return a.pri < b.pri;
    end
    return a.arr < b.arr;
  endfunction

  function automatic void queue_job(job_t j);
    int pos;
    pos = wait_q.size();
    foreach (wait_q[k]) if (precedes(j, wait_q[k])) begin
      pos = k;
      break;
    end
    wait_q.insert(pos, j);
  endfunction

  function automatic logic [39:0] sat_add(logic [39:0] t, logic [63:0] d);
    logic [63:0] s;
    s = 64'(t) + d;
    return s > 64'(MAX40) ? MAX40 : s[39:0];
  endfunction

  function automatic void reset_schedule();
    sched_mode = SCH_FCFS;
    core_limit = 4'd8;
    foreach (core_on[i]) core_on[i] = 0;
    wait_q.delete();
    prev_now = 0;
    fin_cnt = 0;
    wait_tot = 0;
    turn_tot = 0;
    resp_tot = 0;
  endfunction

  function automatic reply_t schedule_event(logic [1:0] act, logic [15:0] id, logic [23:0] now,
                                            logic [23:0] len, logic [15:0] pri, logic [2:0] ci);
    reply_t r;
    job_t j, cand, h, cur;
    logic [23:0] dt;
    int n, victim;
    bit placed;
    logic [63:0] tn, ar, ln, st;
    r.kind = KIND_NONE;
    r.value = '0;
    dt = now >= prev_now ? now - prev_now : '0;
    n = cores_eff();
    for (int i = 0; i < n; i++)
      if (core_on[i])
        core_slot[i].rem = core_slot[i].rem > {1'b0, dt} ? core_slot[i].rem - {1'b0, dt} : '0;
    prev_now = now;
    if (act == ACT_ARRIVE) begin
      j.num = id; j.arr = now; j.start = NO_START; j.len = len; j.rem = {1'b0, len};
      j.pri = pri;
      placed = 0;
      for (int i = 0; i < n && !placed; i++) if (!core_on[i]) begin
        j.start = {1'b0, now};
        core_slot[i] = j;
        core_on[i] = 1;
        r.kind = KIND_CORE; r.value = 16'(i); placed = 1;
      end
      if (!placed && (mode_eff() == SCH_PSJF || mode_eff() == SCH_PPRI)
          && wait_q.size() < QDEPTH) begin
        cand = j;
        victim = -1;
        for (int i = 0; i < n; i++) if (precedes(cand, core_slot[i])) begin
          victim = i;
          cand = core_slot[i];
        end
        if (victim >= 0) begin
          cur = core_slot[victim];
          if (cur.start == {1'b0, now}) cur.start = NO_START;
          j.start = {1'b0, now};
          core_slot[victim] = j;
          queue_job(cur);
          r.kind = KIND_CORE; r.value = 16'(victim); placed = 1;
        end
      end
      if (!placed && wait_q.size() < QDEPTH) queue_job(j);
    end else if (act == ACT_FINISH && int'(ci) < n) begin
      if (core_on[ci]) begin
        tn = 64'(now); ar = 64'(core_slot[ci].arr); ln = 64'(core_slot[ci].len);
        st = 64'(core_slot[ci].start);
        if (fin_cnt != 32'hFFFF_FFFF) fin_cnt++;
        if (tn >= ar + ln) wait_tot = sat_add(wait_tot, tn - ar - ln);
        if (tn >= ar) turn_tot = sat_add(turn_tot, tn - ar);
        if (!st[24] && st >= ar) resp_tot = sat_add(resp_tot, st - ar);
        core_on[ci] = 0;
      end
      if (wait_q.size() > 0) begin
        h = wait_q.pop_front();
        if (h.start[24]) h.start = {1'b0, now};
        core_slot[ci] = h; core_on[ci] = 1;
        r.kind = KIND_JOB; r.value = h.num;
      end
    end else if (act == ACT_EXPIRE && int'(ci) < n) begin
      if (core_on[ci]) begin
        cur = core_slot[ci];
        r.kind = KIND_JOB; r.value = cur.num;
        if (wait_q.size() > 0 && !precedes(cur, wait_q[0])) begin
          h = wait_q.pop_front();
          queue_job(cur);
          if (h.start[24]) h.start = {1'b0, now};
          core_slot[ci] = h;
          r.value = h.num;
        end
      end else if (wait_q.size() > 0) begin
        h = wait_q.pop_front();
        if (h.start[24]) h.start = {1'b0, now};
        core_slot[ci] = h; core_on[ci] = 1;
        r.kind = KIND_JOB; r.value = h.num;
      end
    end
    r.finished = fin_cnt;
    r.waiting = wait_tot;
    r.turnaround = turn_tot;
    r.response = resp_tot;
    return r;
  endfunction

  task automatic send_event(logic [1:0] act, logic [15:0] id, logic [23:0] now,
                            logic [23:0] len, logic [15:0] pri, logic [2:0] ci);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16));
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= act;
    s_tdata <= {5'b0, ci, pri, len, now, id};
    expected_replies.push_back(schedule_event(act, id, now, len, pri, ci));
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(logic idx, logic [3:0] val);
    s_tvalid <= 0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_SCHEME) sched_mode = val[2:0];
    else core_limit = val;
  endtask

  // random event at the current clock, mostly well-formed
  task automatic random_event(int wide_times);
    logic [1:0] act;
    logic [23:0] len;
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 2) clock_now = 24'(clock_now - $urandom_range(0, 50));
    else if (wide_times != 0 && r < 5) clock_now = 24'($urandom);
    else clock_now = 24'(clock_now + $urandom_range(0, 40));
    r = int'($urandom_range(0, 99));
    act = r < 45 ? ACT_ARRIVE : (r < 75 ? ACT_FINISH : (r < 97 ? ACT_EXPIRE : ACT_BAD));
    len = $urandom_range(0, 9) == 0 ? 24'($urandom | 1) : 24'($urandom_range(1, 200));
    send_event(act, 16'($urandom), clock_now, len,
               $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 7)),
               3'($urandom_range(0, 7)));
  endtask

  task automatic test_directed();
    clock_now = 0;
    for (int i = 0; i < 9; i++)
      send_event(ACT_ARRIVE, 16'(32'hFFFF - i), 24'd10, 24'(32'hFFFFFF - i), 16'(i), 3'd0);
    send_event(ACT_FINISH, 16'd0, 24'd5, 24'd0, 16'd0, 3'd0);
    send_event(ACT_EXPIRE, 16'd0, 24'hFFFFFF, 24'd0, 16'd0, 3'd7);
    send_event(ACT_FINISH, 16'd0, 24'hFFFFFF, 24'd0, 16'd0, 3'd7);
    send_event(ACT_BAD, 16'd0, 24'hFFFFFF, 24'd0, 16'd0, 3'd0);
    for (int i = 0; i < 9; i++)
      send_event(ACT_FINISH, 16'd0, 24'hFFFFFF, 24'd0, 16'd0, 3'(i % 8));
    send_event(ACT_EXPIRE, 16'd0, 24'hFFFFFF, 24'd0, 16'd0, 3'd1);
    clock_now = 24'hFFFFFF;
  endtask

  task automatic test_schemes();
    for (int s = 0; s < 8; s++) begin
      write_reg(CFG_SCHEME, 4'(s));
      write_reg(CFG_CORES, (s == 0) ? 4'd0 : (s == 7 ? 4'd15 : 4'($urandom_range(1, 8))));
      repeat (120) random_event(1);
    end
  endtask

  task automatic test_queue_full();
    write_reg(CFG_SCHEME, 4'(SCH_PSJF));
    write_reg(CFG_CORES, 4'd1);
    clock_now = 100;
    repeat (70) send_event(ACT_ARRIVE, 16'($urandom), clock_now,
                           24'($urandom_range(1, 24'hFFFFFF)), 16'($urandom), 3'd0);
    repeat (70) random_event(0);
  endtask

  task automatic test_random();
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_SCHEME, 4'($urandom_range(0, 5)));
      write_reg(CFG_CORES, p == 0 ? 4'd1 : (p == 1 ? 4'd8 : 4'($urandom_range(1, 8))));
      repeat (80) random_event(0);
    end
  endtask

  // sink with random stalls and result checker
  initial begin
    reply_t e;
    int stall;
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16));
      if (stall > 0) begin
        m_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
      if (expected_replies.size() == 0) begin
        $error("unexpected beat: kind %0d value %0d", m_tuser, m_tdata[15:0]);
        errors++;
      end else begin
        e = expected_replies.pop_front();
        if (m_tuser !== e.kind) begin
          $error("reply_kind exp %0d got %0d", e.kind, m_tuser); errors++;
        end
        if (m_tdata[15:0] !== e.value) begin
          $error("reply_value exp %0d got %0d", e.value, m_tdata[15:0]); errors++;
        end
        if (m_tdata[47:16] !== e.finished) begin
          $error("jobs_finished exp %0d got %0d", e.finished, m_tdata[47:16]); errors++;
        end
        if (m_tdata[87:48] !== e.waiting) begin
          $error("waiting_sum exp %0d got %0d", e.waiting, m_tdata[87:48]); errors++;
        end
        if (m_tdata[127:88] !== e.turnaround) begin
          $error("turnaround_sum exp %0d got %0d", e.turnaround, m_tdata[127:88]); errors++;
        end
        if (m_tdata[167:128] !== e.response) begin
          $error("response_sum exp %0d got %0d", e.response, m_tdata[167:128]); errors++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("multicore_job_scheduler_core_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    reset_schedule();
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_schemes();
    test_queue_full();
    test_random();
    s_tvalid <= 0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_replies.size() == 0)
      $display("multicore_job_scheduler_core_tb: done, clean");
    else
      $display("multicore_job_scheduler_core_tb: done, errors");
    $finish;
  end
endmodule
